// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sgrom_pkg.sv
// ---------------------------------------------------------------------------
// sgrom_pkg
// Request/result types, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package sgrom_pkg;

  localparam int FIELD_BITS  = 48;
  localparam int OFFSET_BITS = 36;

  // Request commands
  localparam logic [1:0] CMD_LIST_START = 2'd0;
  localparam logic [1:0] CMD_REGION     = 2'd1;
  localparam logic [1:0] CMD_MAP        = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_SEGMENT    = 3'd0;
  localparam logic [2:0] ST_ACCEPTED   = 3'd1;
  localparam logic [2:0] ST_EMPTY_LIST = 3'd2;
  localparam logic [2:0] ST_TOO_MANY   = 3'd3;
  localparam logic [2:0] ST_MISALIGNED = 3'd4;
  localparam logic [2:0] ST_START_OUT  = 3'd5;
  localparam logic [2:0] ST_END_OUT    = 3'd6;
  localparam logic [2:0] ST_NO_TABLE   = 3'd7;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [7:0]             list_count;
    logic [FIELD_BITS-1:0]  region_base;
    logic [FIELD_BITS-1:0]  region_size;
    logic [OFFSET_BITS-1:0] page_offset;
    logic [FIELD_BITS-1:0]  map_length;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [FIELD_BITS-1:0] frame_number;
    logic [FIELD_BITS-1:0] seg_bytes;
    logic [FIELD_BITS-1:0] seg_start;
    logic                  last;
  } res_t;

  // Controller -> datapath
  typedef struct packed {
    logic       post;        // load a status-only result
    logic [2:0] status;
    logic       wr_en;       // store region entry
    logic       map_load;    // latch map request, rewind index
    logic       rd_en;       // read region table at index
    logic       first_step;  // evaluate start-page search
    logic       last_step;   // evaluate end-byte search
    logic       emit_setup;  // rewind to first region for emission
    logic       emit;        // load one segment result
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic misaligned;
    logic first_hit;
    logic last_hit;
    logic at_end;
    logic emit_done;
    logic out_free;
  } dp_stat_t;

  // Bits to index n entries
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits to hold a count of 0..n
  function automatic int cnt_bits(input int n);
    return $clog2(n + 1);
  endfunction

endpackage

// File: src/sgrom_dpath.sv
// ---------------------------------------------------------------------------
// sgrom_dpath
// Region table memory, walk arithmetic and result register.
// ---------------------------------------------------------------------------
module sgrom_dpath #(
  parameter int MAX_REGION_COUNT = 32,
  parameter int PAGE_BITS        = 12,
  parameter int ADDRESS_BITS     = 48,
  localparam int IW = sgrom_pkg::idx_bits(MAX_REGION_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  input  sgrom_pkg::req_t     req,
  input  logic [IW-1:0]       wr_addr,
  input  logic [IW-1:0]       top_idx,
  input  sgrom_pkg::dp_cmd_t  cmd,
  output sgrom_pkg::dp_stat_t stat,
  output logic                res_valid,
  input  logic                res_stall,
  output sgrom_pkg::res_t     res
);

  localparam int W  = sgrom_pkg::FIELD_BITS;
  localparam int OW = sgrom_pkg::OFFSET_BITS;
  localparam int FW = W - PAGE_BITS;
  localparam logic [W-1:0] ADDR_MASK = (ADDRESS_BITS >= W) ? {W{1'b1}} :
                                       W'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [FW-1:0] frame_mem [MAX_REGION_COUNT];
  logic [W-1:0]  bytes_mem [MAX_REGION_COUNT];
  logic [FW-1:0] rd_frame;
  logic [W-1:0]  rd_bytes;

  logic [IW-1:0] idx, first_idx, last_idx;
  logic [OW-1:0] pgoff, start_pg;
  logic [W-1:0]  length, remaining, mapped;
  logic          out_valid;
  sgrom_pkg::res_t out_q;

  logic [W-1:0]  base_m, size_m;
  logic [W-1:0]  pg_wide, pages, pg_diff, off, avail, seg_len, seg_frame;
  logic [W:0]    end_sum;
  logic          first_hit, last_hit;

  assign base_m = req.region_base & ADDR_MASK;
  assign size_m = req.region_size & ADDR_MASK;

  assign pg_wide   = {{(W-OW){1'b0}}, pgoff};
  assign pages     = rd_bytes >> PAGE_BITS;
  assign first_hit = pg_wide < pages;
  assign pg_diff   = pg_wide - pages;
  // only meaningful once the start page lies inside the current region
  assign off       = pg_wide << PAGE_BITS;
  assign end_sum   = {1'b0, off} + {1'b0, remaining};
  assign last_hit  = end_sum <= {1'b0, rd_bytes};
  assign avail     = rd_bytes - off;
  assign seg_len   = (remaining < avail) ? remaining : avail;
  assign seg_frame = {{PAGE_BITS{1'b0}}, rd_frame} + pg_wide;

  assign stat.misaligned = (base_m[PAGE_BITS-1:0] != '0) || (size_m[PAGE_BITS-1:0] != '0);
  assign stat.first_hit  = first_hit;
  assign stat.last_hit   = last_hit;
  assign stat.at_end     = idx == top_idx;
  assign stat.emit_done  = idx == last_idx;
  assign stat.out_free   = !out_valid || !res_stall;

  // region table, single write / single registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      frame_mem[wr_addr] <= base_m[W-1:PAGE_BITS];
      bytes_mem[wr_addr] <= size_m;
    end
    if (cmd.rd_en) begin
      rd_frame <= frame_mem[idx];
      rd_bytes <= bytes_mem[idx];
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.map_load) begin
      pgoff     <= req.page_offset;
      remaining <= req.map_length;
      length    <= req.map_length;
      idx       <= '0;
    end
    if (cmd.first_step) begin
      if (first_hit) begin
        first_idx <= idx;
        start_pg  <= pgoff;
      end else begin
        pgoff <= pg_diff[OW-1:0];
        idx   <= idx + IW'(1);
      end
    end
    if (cmd.last_step) begin
      if (last_hit) begin
        last_idx <= idx;
      end else begin
        remaining <= remaining - avail;
        pgoff     <= '0;
        idx       <= idx + IW'(1);
      end
    end
    if (cmd.emit_setup) begin
      idx       <= first_idx;
      pgoff     <= start_pg;
      remaining <= length;
      mapped    <= '0;
    end
    if (cmd.emit) begin
      out_q.status       <= sgrom_pkg::ST_SEGMENT;
      out_q.frame_number <= seg_frame;
      out_q.seg_bytes    <= seg_len;
      out_q.seg_start    <= mapped;
      out_q.last         <= idx == last_idx;
      remaining          <= remaining - seg_len;
      mapped             <= mapped + seg_len;
      pgoff              <= '0;
      idx                <= idx + IW'(1);
    end
    if (cmd.post) begin
      out_q.status       <= cmd.status;
      out_q.frame_number <= '0;
      out_q.seg_bytes    <= '0;
      out_q.seg_start    <= '0;
      out_q.last         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!res_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign res_valid = out_valid;
  assign res       = out_q;

endmodule

// File: src/sgrom_ctrl.sv
// ---------------------------------------------------------------------------
// sgrom_ctrl
// Request decode, list bookkeeping and map walk sequencer.
// ---------------------------------------------------------------------------
module sgrom_ctrl #(
  parameter int MAX_REGION_COUNT = 32,
  localparam int IW = sgrom_pkg::idx_bits(MAX_REGION_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sgrom_pkg::req_t     req,
  input  sgrom_pkg::dp_stat_t stat,
  output sgrom_pkg::dp_cmd_t  cmd,
  output logic [IW-1:0]       wr_addr,
  output logic [IW-1:0]       top_idx
);

  localparam int CW = sgrom_pkg::cnt_bits(MAX_REGION_COUNT);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_REGION_COUNT);
  localparam logic [7:0]    MAX_8 = 8'(MAX_REGION_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST_RD, S_FIRST_EV, S_LAST_EV, S_LAST_RD, S_EMIT_RD, S_EMIT
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] expected_count, expected_next;
  logic [CW-1:0] loaded_count, loaded_next;
  logic          table_valid, table_valid_next;
  logic [CW-1:0] loaded_m1;
  logic          accept;

  assign req_stall = (state != S_IDLE) || !stat.out_free;
  assign accept    = req_valid && !req_stall;
  assign loaded_m1 = loaded_count - CW'(1);
  assign wr_addr   = loaded_count[IW-1:0];
  assign top_idx   = loaded_m1[IW-1:0];

  always_comb begin
    state_next       = state;
    expected_next    = expected_count;
    loaded_next      = loaded_count;
    table_valid_next = table_valid;
    cmd              = '0;
    cmd.status       = sgrom_pkg::ST_SEGMENT;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            sgrom_pkg::CMD_LIST_START: begin
              table_valid_next = 1'b0;
              loaded_next      = '0;
              cmd.post         = 1'b1;
              if (req.list_count == 8'd0) begin
                expected_next = '0;
                cmd.status    = sgrom_pkg::ST_EMPTY_LIST;
              end else if (req.list_count > MAX_8) begin
                expected_next = '0;
                cmd.status    = sgrom_pkg::ST_TOO_MANY;
              end else begin
                expected_next = req.list_count[CW-1:0];
                cmd.status    = sgrom_pkg::ST_ACCEPTED;
              end
            end
            sgrom_pkg::CMD_REGION: begin
              cmd.post = 1'b1;
              if (expected_count == '0 || loaded_count >= expected_count ||
                  loaded_count >= MAX_C) begin
                cmd.status = sgrom_pkg::ST_NO_TABLE;
              end else if (stat.misaligned) begin
                expected_next    = '0;
                loaded_next      = '0;
                table_valid_next = 1'b0;
                cmd.status       = sgrom_pkg::ST_MISALIGNED;
              end else begin
                cmd.wr_en   = 1'b1;
                loaded_next = loaded_count + CW'(1);
                if (loaded_next == expected_count) begin
                  table_valid_next = 1'b1;
                end
                cmd.status = sgrom_pkg::ST_ACCEPTED;
              end
            end
            sgrom_pkg::CMD_MAP: begin
              if (!table_valid) begin
                cmd.post   = 1'b1;
                cmd.status = sgrom_pkg::ST_NO_TABLE;
              end else begin
                cmd.map_load = 1'b1;
                state_next   = S_FIRST_RD;
              end
            end
            default: ;  // unused command: dropped silently
          endcase
        end
      end
      S_FIRST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_FIRST_EV;
      end
      S_FIRST_EV: begin
        cmd.first_step = 1'b1;
        if (stat.first_hit) begin
          state_next = S_LAST_EV;   // same region may also hold the end
        end else if (stat.at_end) begin
          cmd.post   = 1'b1;
          cmd.status = sgrom_pkg::ST_START_OUT;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIRST_RD;
        end
      end
      S_LAST_EV: begin
        cmd.last_step = 1'b1;
        if (stat.last_hit) begin
          cmd.emit_setup = 1'b1;
          state_next     = S_EMIT_RD;
        end else if (stat.at_end) begin
          cmd.post   = 1'b1;
          cmd.status = sgrom_pkg::ST_END_OUT;
          state_next = S_IDLE;
        end else begin
          state_next = S_LAST_RD;
        end
      end
      S_LAST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LAST_EV;
      end
      S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.emit_done ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      expected_count <= '0;
      loaded_count   <= '0;
      table_valid    <= 1'b0;
    end else begin
      state          <= state_next;
      expected_count <= expected_next;
      loaded_count   <= loaded_next;
      table_valid    <= table_valid_next;
    end
  end

endmodule

// File: src/sg_region_offset_mapper.sv
// ---------------------------------------------------------------------------
// sg_region_offset_mapper
// Loads a scatter-gather region list and maps page/byte ranges onto it,
// one result per touched region.
// ---------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  request  | req_valid / req_stall | req_data (sgrom_pkg::req_t)
//  result   | res_valid / res_stall | res_data (sgrom_pkg::res_t)
//
// List, region and decode-time errors answer in the cycle after acceptance.
// A map request uses the single registered table read: each region is read,
// then checked for the start page until it is found, then for the end byte;
// each segment region is then read again and emitted once the result is free.
// Sync reset clears controller and list state; the table is never cleared.
// A request is taken only when idle and the result register is free or draining.
//
`include "assert_macros.svh"

module sg_region_offset_mapper #(
  parameter int MAX_REGION_COUNT = 32,
  parameter int PAGE_BITS        = 12,
  parameter int ADDRESS_BITS     = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sgrom_pkg::req_t req_data,
  output logic            res_valid,
  input  logic            res_stall,
  output sgrom_pkg::res_t res_data
);

  localparam int IW = sgrom_pkg::idx_bits(MAX_REGION_COUNT);

  sgrom_pkg::dp_cmd_t  dp_cmd;
  sgrom_pkg::dp_stat_t dp_stat;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       top_idx;
  logic                req_accept;
  logic                res_load;
  logic                res_busy;
  logic                map_start;
  logic                list_start;

  assign req_accept = req_valid && !req_stall;

  // sequencer: decode, list counters, walk states
  sgrom_ctrl #(
    .MAX_REGION_COUNT(MAX_REGION_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_data),
    .stat      (dp_stat),
    .cmd       (dp_cmd),
    .wr_addr   (wr_addr),
    .top_idx   (top_idx)
  );

  // region table, offset arithmetic, result register
  sgrom_dpath #(
    .MAX_REGION_COUNT(MAX_REGION_COUNT),
    .PAGE_BITS       (PAGE_BITS),
    .ADDRESS_BITS    (ADDRESS_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .wr_addr   (wr_addr),
    .top_idx   (top_idx),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_data)
  );

  assign res_load   = dp_cmd.post || dp_cmd.emit;
  assign res_busy   = res_valid && res_stall;
  assign map_start  = req_accept && req_data.cmd == sgrom_pkg::CMD_MAP && !dp_cmd.post;
  assign list_start = req_accept && req_data.cmd == sgrom_pkg::CMD_LIST_START;

  // results are only loaded into a free result register
  `ASSERT_IMPLY(a_load_free, clk, rst, res_load, !res_busy, "result register overwritten")

  // a map walk starts with an empty result register
  `ASSERT_NEXT(a_map_empty, clk, rst, map_start, !res_valid, "stale result at map start")

  // list start always answers on the next cycle with a final result
  `ASSERT_NEXT(a_list_answer, clk, rst, list_start, res_valid && res_data.last, "list start not answered")

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for sg_region_offset_mapper: directed list/map cases,
// then random list loads and map requests with sender gaps and result stalls.
// ---------------------------------------------------------------------------
module testbench;

  localparam int TABLE_DEPTH   = 32;
  localparam int PG_LOG2       = 12;
  localparam int RANDOM_ITEMS  = 140;
  localparam int END_WAIT      = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [47:0] PAGE_BYTES = 48'h1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  sgrom_pkg::req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  sgrom_pkg::res_t res_data;

  // Mapper state as seen by the predictor
  logic [35:0] region_frame_tbl [TABLE_DEPTH];
  logic [47:0] region_len_tbl   [TABLE_DEPTH];
  int          list_expected = 0;
  int          list_loaded   = 0;
  logic        table_ok      = 1'b0;

  sgrom_pkg::res_t pending_results [$];
  int   mismatches  = 0;
  int   items_sent  = 0;
  int   burst_left  = 0;

  sg_region_offset_mapper u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------
  function automatic sgrom_pkg::res_t status_res(input logic [2:0] st);
    sgrom_pkg::res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Walk the table: find the start region, then the end region, then emit
  // one segment per region in between (zero-sized ones give 0-byte segments).
  task automatic map_segments(input logic [35:0] start_page, input logic [47:0] length);
    logic [63:0] pg, first_pg, rest, done, avail, take;
    int i, first_idx, last_idx;
    sgrom_pkg::res_t seg;
    pg = 64'(start_page);
    i = 0;
    while (i < list_loaded && pg >= 64'(region_len_tbl[i] >> PG_LOG2)) begin
      pg -= 64'(region_len_tbl[i] >> PG_LOG2);
      i++;
    end
    if (i >= list_loaded) begin
      pending_results.push_back(status_res(sgrom_pkg::ST_START_OUT));
    end else begin
      first_idx = i;
      first_pg = pg;
      rest = 64'(length);
      while (i < list_loaded && (pg << PG_LOG2) + rest > 64'(region_len_tbl[i])) begin
        rest -= 64'(region_len_tbl[i]) - (pg << PG_LOG2);
        pg = '0;
        i++;
      end
      if (i >= list_loaded) begin
        pending_results.push_back(status_res(sgrom_pkg::ST_END_OUT));
      end else begin
        last_idx = i;
        pg = first_pg;
        rest = 64'(length);
        done = '0;
        for (i = first_idx; i <= last_idx; i++) begin
          avail = 64'(region_len_tbl[i]) - (pg << PG_LOG2);
          take = (rest < avail) ? rest : avail;
          seg.status = sgrom_pkg::ST_SEGMENT;
          seg.frame_number = 48'(64'(region_frame_tbl[i]) + pg);
          seg.seg_bytes = take[47:0];
          seg.seg_start = done[47:0];
          seg.last = (i == last_idx);
          pending_results.push_back(seg);
          rest -= take;
          done += take;
          pg = '0;
        end
      end
    end
  endtask

  // Update the table for one accepted request and queue what it produces.
  task automatic apply_request(input sgrom_pkg::req_t r);
    logic [47:0] base, size;
    int cnt;
    case (r.cmd)
      sgrom_pkg::CMD_LIST_START: begin
        table_ok = 1'b0;
        list_loaded = 0;
        cnt = int'(r.list_count);
        if (cnt == 0) begin
          list_expected = 0;
          pending_results.push_back(status_res(sgrom_pkg::ST_EMPTY_LIST));
        end else if (cnt > TABLE_DEPTH) begin
          list_expected = 0;
          pending_results.push_back(status_res(sgrom_pkg::ST_TOO_MANY));
        end else begin
          list_expected = cnt;
          pending_results.push_back(status_res(sgrom_pkg::ST_ACCEPTED));
        end
      end
      sgrom_pkg::CMD_REGION: begin
        base = r.region_base;
        size = r.region_size;
        if (list_expected == 0 || list_loaded >= list_expected ||
            list_loaded >= TABLE_DEPTH) begin
          pending_results.push_back(status_res(sgrom_pkg::ST_NO_TABLE));
        end else if (base[PG_LOG2-1:0] != 0 || size[PG_LOG2-1:0] != 0) begin
          // bad entry kills the whole pending list
          list_expected = 0;
          list_loaded = 0;
          table_ok = 1'b0;
          pending_results.push_back(status_res(sgrom_pkg::ST_MISALIGNED));
        end else begin
          region_frame_tbl[list_loaded] = base[47:PG_LOG2];
          region_len_tbl[list_loaded] = size;
          list_loaded++;
          if (list_loaded == list_expected) table_ok = 1'b1;
          pending_results.push_back(status_res(sgrom_pkg::ST_ACCEPTED));
        end
      end
      sgrom_pkg::CMD_MAP: begin
        if (!table_ok) pending_results.push_back(status_res(sgrom_pkg::ST_NO_TABLE));
        else map_segments(r.page_offset, r.map_length);
      end
      default: ;  // unused command: no result
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR at %0t: %s got 'h%0h expected 'h%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    sgrom_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status",
                        64'(res_data.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (res_data.status !== want.status)
          report_mismatch("status", 64'(res_data.status), 64'(want.status));
        if (res_data.frame_number !== want.frame_number)
          report_mismatch("frame_number", 64'(res_data.frame_number),
                          64'(want.frame_number));
        if (res_data.seg_bytes !== want.seg_bytes)
          report_mismatch("seg_bytes", 64'(res_data.seg_bytes), 64'(want.seg_bytes));
        if (res_data.seg_start !== want.seg_start)
          report_mismatch("seg_start", 64'(res_data.seg_start), 64'(want.seg_start));
        if (res_data.last !== want.last)
          report_mismatch("last", 64'(res_data.last), 64'(want.last));
      end
    end
  end

  // Result stall: random stretches of free flow, light and heavy stalling
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // -------------------------------------------------------------------------
  // Request driving
  // -------------------------------------------------------------------------
  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // Unused fields carry random bits so every input bit toggles.
  function automatic sgrom_pkg::req_t random_req(input logic [1:0] cmd);
    sgrom_pkg::req_t r;
    r.cmd = cmd;
    r.list_count = 8'($urandom);
    r.region_base = 48'(rand_word64());
    r.region_size = 48'(rand_word64());
    r.page_offset = 36'(rand_word64());
    r.map_length = 48'(rand_word64());
    return r;
  endfunction

  function automatic sgrom_pkg::req_t list_req(input logic [7:0] count);
    sgrom_pkg::req_t r;
    r = random_req(sgrom_pkg::CMD_LIST_START);
    r.list_count = count;
    return r;
  endfunction

  function automatic sgrom_pkg::req_t region_req(input logic [47:0] base,
                                                 input logic [47:0] size);
    sgrom_pkg::req_t r;
    r = random_req(sgrom_pkg::CMD_REGION);
    r.region_base = base;
    r.region_size = size;
    return r;
  endfunction

  function automatic sgrom_pkg::req_t map_req(input logic [35:0] page,
                                              input logic [47:0] len);
    sgrom_pkg::req_t r;
    r = random_req(sgrom_pkg::CMD_MAP);
    r.page_offset = page;
    r.map_length = len;
    return r;
  endfunction

  // Valid stays up across a burst; a gap follows when the burst runs out.
  task automatic send_req(input sgrom_pkg::req_t r);
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_request(r);
    if (r.cmd != CMD_UNUSED) items_sent++;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      burst_left = $urandom_range(0, 15);
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained(input int extra);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Directed tests
  // -------------------------------------------------------------------------
  task automatic test_status_errors();
    send_req(map_req(0, 0));              // no table yet
    send_req(region_req(0, PAGE_BYTES));  // no list pending
    send_req(list_req(0));
    send_req(list_req(8'(TABLE_DEPTH + 1)));
    send_req(list_req(8'hFF));
    send_req(region_req(0, PAGE_BYTES));  // rejected list leaves nothing pending
    send_req(random_req(CMD_UNUSED));     // ignored, no result
  endtask

  task automatic test_misaligned_entries();
    send_req(list_req(2));
    send_req(region_req(48'h1, PAGE_BYTES));      // bad base
    send_req(region_req(48'h2000, PAGE_BYTES));   // list already dropped
    send_req(list_req(2));
    send_req(region_req(48'h3000, 48'h800));      // bad size
  endtask

  task automatic test_single_region();
    send_req(list_req(1));
    send_req(region_req({36'hF_FFFF_FFFF, 12'h0}, 3 * PAGE_BYTES));
    send_req(map_req(0, 0));                      // zero length
    send_req(map_req(0, 3 * PAGE_BYTES));         // exactly the buffer
    send_req(map_req(1, 2 * PAGE_BYTES + 1));     // end past the buffer
    send_req(map_req(3, 0));                      // start past the buffer
  endtask

  task automatic test_zero_sized_region();
    send_req(list_req(3));
    send_req(region_req(48'h1000, 2 * PAGE_BYTES));
    send_req(region_req(48'h8000_0000, 0));
    send_req(region_req(48'h5000, PAGE_BYTES));
    send_req(map_req(1, 2 * PAGE_BYTES));         // spans the empty region
    send_req(region_req(48'h6000, PAGE_BYTES));   // list already complete
    send_req(map_req(2, 0));                      // start lands past the empty one
  endtask

  task automatic test_huge_region();
    send_req(list_req(1));
    send_req(region_req(0, 48'hFFFF_FFFF_F000));
    send_req(map_req(36'hF_FFFF_FFFE, 48'hFFF));
    send_req(map_req(36'hF_FFFF_FFFF, 0));
    send_req(map_req(0, 48'hFFFF_FFFF_FFFF));
  endtask

  // -------------------------------------------------------------------------
  // Random traffic
  // -------------------------------------------------------------------------
  function automatic logic [47:0] random_region_size();
    logic [47:0] v;
    case ($urandom_range(0, 19))
      0, 1: v = '0;
      2: v = 48'(rand_word64()) & ~48'hFFF;
      default: v = 48'($urandom_range(1, 4)) << PG_LOG2;
    endcase
    return v;
  endfunction

  function automatic logic [47:0] misaligned_value();
    logic [47:0] v;
    v = 48'(rand_word64());
    if (v[PG_LOG2-1:0] == 0) v[0] = 1'b1;
    return v;
  endfunction

  // Map aimed at the loaded table, mostly landing inside the buffer
  function automatic sgrom_pkg::req_t random_map_req();
    logic [63:0] total_pages, total_bytes, pg, rem, len;
    int i;
    total_pages = 0;
    total_bytes = 0;
    for (i = 0; i < list_loaded; i++) begin
      total_pages += 64'(region_len_tbl[i] >> PG_LOG2);
      total_bytes += 64'(region_len_tbl[i]);
    end
    pg = rand_word64() % (total_pages + 2);
    rem = ((pg << PG_LOG2) < total_bytes) ? total_bytes - (pg << PG_LOG2) : 0;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = rem;
      2: len = rem + 1;
      3: len = rand_word64();
      default: len = rand_word64() % (rem + 1);
    endcase
    return map_req(pg[35:0], len[47:0]);
  endfunction

  task automatic test_random_traffic();
    int start_count, n, j, maps;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: send_req(list_req(0));
        1: send_req(list_req(8'($urandom_range(TABLE_DEPTH + 1, 255))));
        2: send_req(random_req(sgrom_pkg::CMD_MAP));
        3: send_req(region_req(misaligned_value(), 48'(rand_word64())));
        4: send_req(random_req(CMD_UNUSED));
        default: begin
          // well-formed list, then maps into it
          n = ($urandom_range(0, 7) == 0) ? TABLE_DEPTH : $urandom_range(1, 6);
          send_req(list_req(8'(n)));
          for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 39) == 0)
              send_req(region_req(48'(rand_word64()), misaligned_value()));
            else if ($urandom_range(0, 39) == 0)
              send_req(random_req(sgrom_pkg::CMD_MAP));   // map before the list completes
            else
              send_req(region_req(48'(rand_word64()) & ~48'hFFF, random_region_size()));
          end
          if ($urandom_range(0, 5) == 0)
            send_req(region_req(48'(rand_word64()) & ~48'hFFF, PAGE_BYTES));
          maps = $urandom_range(1, 4);
          for (j = 0; j < maps; j++) send_req(random_map_req());
        end
      endcase
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_status_errors();
    wait_drained(8);
    test_misaligned_entries();
    wait_drained(8);
    test_single_region();
    wait_drained(8);
    test_zero_sized_region();
    wait_drained(8);
    test_huge_region();
    wait_drained(8);
    test_random_traffic();
    wait_drained(END_WAIT);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
